// ===== hw/rtl/small_matrix_multiply_assert.svh =====
// Assertion macros used by the checker of the matrix multiplier.
`ifndef SMALL_MATRIX_MULTIPLY_ASSERT_SVH
`define SMALL_MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/smm_pkg.sv =====
// Types, constants and helper functions of the small matrix multiplier.
package smm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int ELEM_BITS = 16;
  localparam int DIM_W     = 4;
  localparam int IDX_W     = 3;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = 6;
  localparam int CNT_W     = 7;
  localparam int TOT_W     = 8;
  localparam int PROD_W    = 2 * ELEM_BITS;
  localparam int ACC_W     = PROD_W + 4;
  localparam int RES_W     = 32;
  localparam int CFG_AW    = 2;

  localparam logic [CFG_AW-1:0] CFG_ROWS_A     = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_COLS_B     = 2'd2;

  typedef enum logic [1:0] {
    S_LOAD,
    S_ISSUE,
    S_EMIT
  } state_t;

  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] raw);
    logic [DIM_W-1:0] res;
    if (raw == '0) begin
      res = DIM_W'(1);
    end else if (raw > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = raw;
    end
    return res;
  endfunction

  function automatic logic [RES_W-1:0] sat_res(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic [RES_W-1:0]        res;
    hi = ACC_W'(signed'({1'b0, {(RES_W-1){1'b1}}}));
    lo = -hi - ACC_W'(1);
    if (v > hi) begin
      res = {1'b0, {(RES_W-1){1'b1}}};
    end else if (v < lo) begin
      res = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      res = v[RES_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/small_matrix_multiply.sv =====
// Top level of the small matrix multiplier: element stores, sequencer and shared MAC.
// Computes C = A x B for sizes of 1 to 8 set by the rows_a, inner_size and cols_b
// registers. Elements arrive one per transaction, all of A then all of B, row-major;
// in_tready stays high throughout the load. The transaction that completes B drops
// in_tready until the last element of C sits in the output register. Each element of C
// sums k products (k = inner size) in a single 16x16 multiply-accumulate unit fed by
// registered reads of the two element memories; a new element of C starts only after the
// previous one enters the output register. Results leave row-major as Q16.16, saturated
// to 32 bits, with their row and column, and tlast on the final element.
module small_matrix_multiply (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [smm_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [smm_pkg::DIM_W-1:0]   cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // elem_value[15:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [39:0]                 out_tdata,  // result_value[31:0], result_row[34:32],
                                                  // result_col[37:35], zero[39:38]
  output logic                        out_tlast
);

  logic [smm_pkg::DIM_W-1:0] rows_a_r, inner_size_r, cols_b_r;
  logic [smm_pkg::DIM_W-1:0] m_eff, k_eff, n_eff;
  logic [smm_pkg::CNT_W-1:0] size_a, size_b, b_idx;
  logic [smm_pkg::TOT_W-1:0] total, cnt_inc;

  smm_pkg::state_t           state_r, state_nxt;
  logic [smm_pkg::CNT_W-1:0] load_cnt_r, load_cnt_nxt;
  logic [smm_pkg::IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, p_r, p_nxt;
  logic [smm_pkg::ADDR_W-1:0] a_base_r, a_base_nxt, a_addr_r, a_addr_nxt;
  logic [smm_pkg::ADDR_W-1:0] b_addr_r, b_addr_nxt;

  logic in_fire, wr_a, wr_b, issue, acc_clr, out_load, out_free;
  logic p_last, i_last, j_last;

  logic signed [smm_pkg::ELEM_BITS-1:0] mem_a [smm_pkg::DEPTH];
  logic signed [smm_pkg::ELEM_BITS-1:0] mem_b [smm_pkg::DEPTH];
  logic signed [smm_pkg::ELEM_BITS-1:0] elem;
  logic signed [smm_pkg::ELEM_BITS-1:0] rd_a_r, rd_b_r;
  logic signed [smm_pkg::PROD_W-1:0]    prod_r;
  logic signed [smm_pkg::ACC_W-1:0]     acc_r;
  logic rd_vld_r, rd_last_r, prod_vld_r, prod_last_r, acc_done_r;

  logic                          out_tvalid_r, out_tlast_r;
  logic [smm_pkg::RES_W-1:0]     out_value_r;
  logic [smm_pkg::IDX_W-1:0]     out_row_r, out_col_r;

  assign m_eff   = smm_pkg::eff_size(rows_a_r);
  assign k_eff   = smm_pkg::eff_size(inner_size_r);
  assign n_eff   = smm_pkg::eff_size(cols_b_r);
  assign size_a  = smm_pkg::CNT_W'(m_eff) * smm_pkg::CNT_W'(k_eff);
  assign size_b  = smm_pkg::CNT_W'(k_eff) * smm_pkg::CNT_W'(n_eff);
  assign total   = smm_pkg::TOT_W'(size_a) + smm_pkg::TOT_W'(size_b);
  assign cnt_inc = smm_pkg::TOT_W'(load_cnt_r) + smm_pkg::TOT_W'(1);
  assign b_idx   = load_cnt_r - size_a;
  assign elem    = in_tdata[smm_pkg::ELEM_BITS-1:0];

  assign in_tready = (state_r == smm_pkg::S_LOAD);
  assign in_fire   = in_tvalid && in_tready;
  assign wr_a      = in_fire && (load_cnt_r < size_a);
  assign wr_b      = in_fire && !(load_cnt_r < size_a) && (b_idx < smm_pkg::CNT_W'(smm_pkg::DEPTH));

  assign p_last   = (smm_pkg::DIM_W'(p_r) == k_eff - smm_pkg::DIM_W'(1));
  assign i_last   = (smm_pkg::DIM_W'(i_r) == m_eff - smm_pkg::DIM_W'(1));
  assign j_last   = (smm_pkg::DIM_W'(j_r) == n_eff - smm_pkg::DIM_W'(1));
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r     <= smm_pkg::DIM_W'(smm_pkg::MAX_DIM);
      inner_size_r <= smm_pkg::DIM_W'(smm_pkg::MAX_DIM);
      cols_b_r     <= smm_pkg::DIM_W'(smm_pkg::MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        smm_pkg::CFG_ROWS_A:     rows_a_r     <= cfg_wdata;
        smm_pkg::CFG_INNER_SIZE: inner_size_r <= cfg_wdata;
        smm_pkg::CFG_COLS_B:     cols_b_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[load_cnt_r[smm_pkg::ADDR_W-1:0]] <= elem;
    end
    rd_a_r <= mem_a[a_addr_r];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[b_idx[smm_pkg::ADDR_W-1:0]] <= elem;
    end
    rd_b_r <= mem_b[b_addr_r];
  end

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    p_nxt        = p_r;
    a_base_nxt   = a_base_r;
    a_addr_nxt   = a_addr_r;
    b_addr_nxt   = b_addr_r;
    issue        = 1'b0;
    acc_clr      = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      smm_pkg::S_LOAD: begin
        if (in_fire) begin
          if (cnt_inc < total) begin
            load_cnt_nxt = cnt_inc[smm_pkg::CNT_W-1:0];
          end else begin
            load_cnt_nxt = '0;
            state_nxt    = smm_pkg::S_ISSUE;
            i_nxt        = '0;
            j_nxt        = '0;
            p_nxt        = '0;
            a_base_nxt   = '0;
            a_addr_nxt   = '0;
            b_addr_nxt   = '0;
            acc_clr      = 1'b1;
          end
        end
      end
      smm_pkg::S_ISSUE: begin
        issue      = 1'b1;
        p_nxt      = p_r + smm_pkg::IDX_W'(1);
        a_addr_nxt = a_addr_r + smm_pkg::ADDR_W'(1);
        b_addr_nxt = b_addr_r + smm_pkg::ADDR_W'(n_eff);
        if (p_last) begin
          p_nxt     = '0;
          state_nxt = smm_pkg::S_EMIT;
        end
      end
      smm_pkg::S_EMIT: begin
        if (acc_done_r && out_free) begin
          out_load = 1'b1;
          if (i_last && j_last) begin
            state_nxt = smm_pkg::S_LOAD;
          end else begin
            state_nxt = smm_pkg::S_ISSUE;
            acc_clr   = 1'b1;
            if (j_last) begin
              i_nxt      = i_r + smm_pkg::IDX_W'(1);
              j_nxt      = '0;
              a_base_nxt = a_base_r + smm_pkg::ADDR_W'(k_eff);
              a_addr_nxt = a_base_r + smm_pkg::ADDR_W'(k_eff);
              b_addr_nxt = '0;
            end else begin
              j_nxt      = j_r + smm_pkg::IDX_W'(1);
              a_addr_nxt = a_base_r;
              b_addr_nxt = smm_pkg::ADDR_W'(j_r) + smm_pkg::ADDR_W'(1);
            end
          end
        end
      end
      default: state_nxt = smm_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= smm_pkg::S_LOAD;
      load_cnt_r <= '0;
      i_r        <= '0;
      j_r        <= '0;
      p_r        <= '0;
      a_base_r   <= '0;
      a_addr_r   <= '0;
      b_addr_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      p_r        <= p_nxt;
      a_base_r   <= a_base_nxt;
      a_addr_r   <= a_addr_nxt;
      b_addr_r   <= b_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
      prod_vld_r  <= 1'b0;
      prod_last_r <= 1'b0;
      acc_done_r  <= 1'b0;
    end else begin
      rd_vld_r    <= issue;
      rd_last_r   <= issue && p_last;
      prod_vld_r  <= rd_vld_r;
      prod_last_r <= rd_last_r;
      if (acc_clr) begin
        acc_done_r <= 1'b0;
      end else if (prod_vld_r && prod_last_r) begin
        acc_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      prod_r <= rd_a_r * rd_b_r;
    end
    if (acc_clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + smm_pkg::ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= smm_pkg::sat_res(acc_r);
      out_row_r   <= i_r;
      out_col_r   <= j_r;
      out_tlast_r <= i_last && j_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_tlast_r;
  assign out_tdata  = {2'b00, out_col_r, out_row_r, out_value_r};

endmodule

// ===== hw/rtl/smm_checker.sv =====
// Port-level checker for the small matrix multiplier, bound to its top level.
`include "small_matrix_multiply_assert.svh"

module smm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  `SMM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result transaction changed")
  `SMM_ASSERT_NOW(a_ready_fall, clk, rst_n, $fell(in_tready), $past(in_tvalid), "input stopped without a completing transaction")
  `SMM_ASSERT_NOW(a_busy_mid, clk, rst_n, out_tvalid && !out_tlast, !in_tready, "input taken while the product is still being emitted")
  `SMM_ASSERT_NOW(a_ready_rise, clk, rst_n, $rose(in_tready), out_tvalid && out_tlast, "input reopened before the final result was loaded")

endmodule

bind small_matrix_multiply smm_checker u_smm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
